// File: hdl/slng_pkg.sv
// Package for the square lattice neighbour generator.
// Field widths, register and direction codes, and the structs passed between stages.
// No dependencies.
`default_nettype none

package slng_pkg;

   localparam int SITE_W       = 20;
   localparam int SIDE_W       = 11;
   localparam int TOPO_W       = 2;
   localparam int DIR_W        = 2;
   localparam int CNT_W        = 2 * SIDE_W;
   localparam int NLINK        = 4;
   localparam int MAX_SIDE_DEF = 1024;

   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;
   localparam int REG_IDX_W = 1;

   localparam logic [REG_IDX_W-1:0] REG_SIDE = 1'b0;
   localparam logic [REG_IDX_W-1:0] REG_TOPO = 1'b1;

   localparam logic [SIDE_W-1:0] SIDE_RESET = 11'd4;

   localparam logic [TOPO_W-1:0] TOPO_TORUS    = 2'd0;
   localparam logic [TOPO_W-1:0] TOPO_CYLINDER = 2'd1;

   localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
   localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd1;
   localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd2;
   localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd3;

   typedef struct packed {
      logic [SIDE_W-1:0] side_length;
      logic [TOPO_W-1:0] topology;
   } cfg_type;

   typedef struct packed {
      logic [SITE_W-1:0] site;
      logic [SITE_W-1:0] rem;
      logic [SIDE_W-1:0] side;
      logic [CNT_W-1:0]  count;
   } div_type;

   typedef struct packed {
      logic [SITE_W-1:0] neighbor;
      logic [DIR_W-1:0]  dir;
      logic              oor;
   } link_type;

   typedef struct packed {
      logic [SITE_W-1:0]          source;
      link_type [NLINK-1:0]       slot;
      logic [NLINK-1:0]           mask;
   } bundle_type;

endpackage

`default_nettype wire

// File: hdl/slng_if.sv
// Channel interfaces for the square lattice neighbour generator.
// Valid/ready channels for site requests and link results; depends on slng_pkg.
`default_nettype none

interface slng_req_if import slng_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SITE_W-1:0] site;

   modport source (output valid, output site, input ready);
   modport sink (input valid, input site, output ready);
endinterface

interface slng_rsp_if import slng_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [SITE_W-1:0] source_site;
   logic [SITE_W-1:0] neighbor_site;
   logic [DIR_W-1:0]  direction;
   logic              is_last;
   logic              out_of_range;

   modport source (output valid, output source_site, output neighbor_site,
                   output direction, output is_last, output out_of_range, input ready);
   modport sink (input valid, input source_site, input neighbor_site,
                 input direction, input is_last, input out_of_range, output ready);
endinterface

`default_nettype wire

// File: hdl/slng_csr.sv
// APB register file of the neighbour generator: side length and topology.
// Depends on slng_pkg.
`default_nettype none

module slng_csr import slng_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [CSR_AW-1:0] paddr,
   input  wire logic [CSR_DW-1:0] pwdata,
   output logic      [CSR_DW-1:0] prdata,
   output logic                   pready,
   output cfg_type                cfg
);

   logic [SIDE_W-1:0]    side_ff, side_in;
   logic [TOPO_W-1:0]    topo_ff, topo_in;
   logic [REG_IDX_W-1:0] idx;
   logic                 wr;

   assign idx    = paddr[CSR_AW-1 -: REG_IDX_W];
   assign wr     = psel && penable && pwrite && pready;
   assign pready = 1'b1;

   always_comb begin
      side_in = side_ff;
      topo_in = topo_ff;
      if (wr) begin
         unique case (idx)
            REG_SIDE: side_in = pwdata[SIDE_W-1:0];
            REG_TOPO: topo_in = pwdata[TOPO_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= SIDE_RESET;
         topo_ff <= TOPO_TORUS;
      end else begin
         side_ff <= side_in;
         topo_ff <= topo_in;
      end
   end

   always_comb begin
      unique case (idx)
         REG_SIDE: prdata = CSR_DW'(side_ff);
         REG_TOPO: prdata = CSR_DW'(topo_ff);
         default:  prdata = '0;
      endcase
   end

   assign cfg.side_length = side_ff;
   assign cfg.topology    = topo_ff;

endmodule

`default_nettype wire

// File: hdl/slng_div_step.sv
// One restoring step of the site-by-side remainder, as a registered pipeline stage.
// Subtracts side shifted by SHIFT where it fits; depends on slng_pkg.
`default_nettype none

module slng_div_step import slng_pkg::*; #(
   parameter int QW    = 10,
   parameter int SHIFT = 0
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_ready,
   input  wire div_type in_data,
   output logic         out_valid,
   input  wire logic    out_ready,
   output div_type      out_data
);

   localparam int CW = (SIDE_W + QW > SITE_W) ? SIDE_W + QW : SITE_W;

   logic [CW-1:0] divisor;
   logic [CW-1:0] rem_x;
   logic [CW-1:0] diff;
   div_type       data_ff, data_in;
   logic          valid_ff;

   always_comb begin
      divisor = CW'(in_data.side) << SHIFT;
      rem_x   = CW'(in_data.rem);
      diff    = rem_x - divisor;
      data_in = in_data;
      if (rem_x >= divisor) begin
         data_in.rem = diff[SITE_W-1:0];
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// File: hdl/slng_emit.sv
// Link stage and result sequencer: builds up to four neighbour links per site,
// then sends them one per cycle while rsp is ready, in topology order. Depends on slng_pkg, slng_if.
`default_nettype none

module slng_emit import slng_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [TOPO_W-1:0] topology,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire div_type           in_data,
   slng_rsp_if.source             rsp
);

   localparam int AW = CNT_W + 1;

   logic [AW-1:0]     site_x, side_x, cnt_x, right_s;
   logic [AW-1:0]     up_w, down_w, left_w, right_w;
   logic [SIDE_W-1:0] pos, sm1;
   logic              oor, at_first, at_last, has_left, has_right;
   link_type          l_up, l_down, l_left, l_right;
   bundle_type        lnk_ff, lnk_in, out_ff;
   logic              lnk_v_ff, out_v_ff, lnk_ready, out_ready_up, fire, last;
   logic [1:0]        pick_idx;
   logic [NLINK-1:0]  pick;

   // Build links
   always_comb begin
      site_x    = AW'(in_data.site);
      side_x    = AW'(in_data.side);
      cnt_x     = AW'(in_data.count);
      pos       = in_data.rem[SIDE_W-1:0];
      sm1       = in_data.side - SIDE_W'(1);
      oor       = (in_data.side == '0) || (site_x >= cnt_x);
      at_first  = pos == '0;
      at_last   = pos == sm1;
      right_s   = site_x + side_x;
      has_left  = site_x >= side_x;
      has_right = right_s < cnt_x;
      up_w      = at_first ? site_x + side_x - AW'(1) : site_x - AW'(1);
      down_w    = at_last ? site_x - AW'(sm1) : site_x + AW'(1);
      left_w    = has_left ? site_x - side_x : site_x + cnt_x - side_x;
      right_w   = has_right ? right_s : right_s - cnt_x;

      l_up    = '{neighbor: up_w[SITE_W-1:0], dir: DIR_UP, oor: 1'b0};
      l_down  = '{neighbor: down_w[SITE_W-1:0], dir: DIR_DOWN, oor: 1'b0};
      l_left  = '{neighbor: left_w[SITE_W-1:0], dir: DIR_LEFT, oor: 1'b0};
      l_right = '{neighbor: right_w[SITE_W-1:0], dir: DIR_RIGHT, oor: 1'b0};

      lnk_in.source = in_data.site;
      if (oor) begin
         lnk_in.slot    = '0;
         lnk_in.slot[0] = '{neighbor: '0, dir: DIR_UP, oor: 1'b1};
         lnk_in.mask    = 4'b0001;
      end else if (topology == TOPO_TORUS) begin
         lnk_in.slot = {l_right, l_down, l_left, l_up};
         lnk_in.mask = 4'b1111;
      end else if (topology == TOPO_CYLINDER) begin
         lnk_in.slot = {l_right, l_left, l_down, l_up};
         lnk_in.mask = {has_right, has_left, 2'b11};
      end else begin
         lnk_in.slot = {l_right, l_left, l_down, l_up};
         lnk_in.mask = {has_right, has_left, !at_last, !at_first};
      end
   end

   assign lnk_ready = !lnk_v_ff || out_ready_up;
   assign in_ready  = lnk_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         lnk_v_ff <= 1'b0;
      end else if (lnk_ready) begin
         lnk_v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (lnk_ready && in_valid) begin
         lnk_ff <= lnk_in;
      end
   end

   // Send links
   always_comb begin
      pick_idx = 2'd0;
      for (int i = NLINK - 1; i >= 0; i--) begin
         if (out_ff.mask[i]) begin
            pick_idx = 2'(i);
         end
      end
      pick = NLINK'(1) << pick_idx;
   end

   assign last         = (out_ff.mask & ~pick) == '0;
   assign fire         = out_v_ff && rsp.ready;
   assign out_ready_up = !out_v_ff || (fire && last);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else if (out_ready_up) begin
         out_v_ff <= lnk_v_ff && (lnk_ff.mask != '0);
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready_up && lnk_v_ff) begin
         out_ff <= lnk_ff;
      end else if (fire) begin
         out_ff.mask <= out_ff.mask & ~pick;
      end
   end

   assign rsp.valid         = out_v_ff;
   assign rsp.source_site   = out_ff.source;
   assign rsp.neighbor_site = out_ff.slot[pick_idx].neighbor;
   assign rsp.direction     = out_ff.slot[pick_idx].dir;
   assign rsp.out_of_range  = out_ff.slot[pick_idx].oor;
   assign rsp.is_last       = last;

endmodule

`default_nettype wire

// File: hdl/square_lattice_neighbor_generator.sv
// Square lattice neighbour generator, top level.
// Depends on slng_pkg, slng_if, slng_csr, slng_div_step and slng_emit.
//
// Usage: send a site index on req_chan; the block returns that site's neighbour
// links on rsp_chan, one item per link, the final one flagged is_last. Torus
// gives up, left, down, right; cylinder and open give up, down, left, right,
// dropping links that do not exist. A site at or beyond side squared gives one
// item with out_of_range set. An open lattice of side one gives no items.
// Side length and topology are set through the csr_ APB port while idle.
// Pipeline: an input register, then one divide stage per quotient bit, Q stages
// where Q is the bit count of the largest quotient (10 at MAX_SIDE 1024), then
// a link register and an output register. Throughput: one link per cycle while
// rsp_chan is ready; the sequencer at the output sets that rate.
// Reset clears all pipeline valid bits and sets side 4, torus. When rsp_chan
// stalls the pipeline fills and then req_chan.ready drops; nothing is lost.
`default_nettype none

module square_lattice_neighbor_generator import slng_pkg::*; #(
   parameter int MAX_SIDE = MAX_SIDE_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   slng_req_if.sink               req_chan,
   slng_rsp_if.source             rsp_chan,
   input  wire logic              csr_psel,
   input  wire logic              csr_penable,
   input  wire logic              csr_pwrite,
   input  wire logic [CSR_AW-1:0] csr_paddr,
   input  wire logic [CSR_DW-1:0] csr_pwdata,
   output logic      [CSR_DW-1:0] csr_prdata,
   output logic                   csr_pready
);

   localparam int SIDE_CAP = (MAX_SIDE < (2 ** SIDE_W) - 1) ? MAX_SIDE : (2 ** SIDE_W) - 1;
   localparam int QW       = (SIDE_CAP > 1) ? $clog2(SIDE_CAP) : 1;

   cfg_type           cfg;
   logic [SIDE_W-1:0] side_sat;
   logic [CNT_W-1:0]  count_in;
   div_type           front_ff;
   logic              front_v_ff;

   div_type           d_chain [QW+1];
   logic              v_chain [QW+1];
   logic              r_chain [QW+1];

   slng_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // Saturate side and square it
   always_comb begin
      if (32'(cfg.side_length) > 32'(MAX_SIDE)) begin
         side_sat = SIDE_W'(MAX_SIDE);
      end else begin
         side_sat = cfg.side_length;
      end
      count_in = CNT_W'(side_sat) * CNT_W'(side_sat);
   end

   assign req_chan.ready = !front_v_ff || r_chain[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         front_v_ff <= 1'b0;
      end else if (req_chan.ready) begin
         front_v_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_chan.ready && req_chan.valid) begin
         front_ff.site  <= req_chan.site;
         front_ff.rem   <= req_chan.site;
         front_ff.side  <= side_sat;
         front_ff.count <= count_in;
      end
   end

   assign d_chain[0] = front_ff;
   assign v_chain[0] = front_v_ff;

   for (genvar i = 0; i < QW; i++) begin : g_div
      slng_div_step #(
         .QW    (QW),
         .SHIFT (QW - 1 - i)
      ) u_step (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (v_chain[i]),
         .in_ready  (r_chain[i]),
         .in_data   (d_chain[i]),
         .out_valid (v_chain[i+1]),
         .out_ready (r_chain[i+1]),
         .out_data  (d_chain[i+1])
      );
   end

   slng_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .topology (cfg.topology),
      .in_valid (v_chain[QW]),
      .in_ready (r_chain[QW]),
      .in_data  (d_chain[QW]),
      .rsp      (rsp_chan)
   );

endmodule

`default_nettype wire

// File: tb/tb_slng_link_checker.sv
// Link checker for the square lattice neighbour generator testbench.
// Watches the request, result and register channels, predicts each site's links
// and compares them in order; depends on slng_pkg and slng_if.
`timescale 1ns / 100ps

module tb_slng_link_checker import slng_pkg::*; #(
   parameter int MAX_SIDE = MAX_SIDE_DEF
) (
   input  logic              clock,
   input  logic              reset,
   slng_req_if               req_mon,
   slng_rsp_if               rsp_mon,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [CSR_AW-1:0] csr_paddr,
   input  logic [CSR_DW-1:0] csr_pwdata,
   input  logic              csr_pready,
   output int                mismatches,
   output int                outstanding,
   output int                links_checked
);

   typedef struct packed {
      logic [SITE_W-1:0] source_site;
      logic [SITE_W-1:0] neighbor_site;
      logic [DIR_W-1:0]  direction;
      logic              is_last;
      logic              out_of_range;
   } lattice_link_type;

   logic [SIDE_W-1:0] side_reg;
   logic [TOPO_W-1:0] topo_reg;
   lattice_link_type  awaited_links[$];
   int                fault_count;
   int                link_count;

   initial begin
      mismatches    = 0;
      outstanding   = 0;
      links_checked = 0;
      fault_count   = 0;
      link_count    = 0;
      side_reg      = SIDE_RESET;
      topo_reg      = TOPO_TORUS;
   end

   function automatic lattice_link_type make_link(input logic [SITE_W-1:0] src,
                                                  input int unsigned nb,
                                                  input logic [DIR_W-1:0] dir);
      lattice_link_type l;
      l.source_site   = src;
      l.neighbor_site = nb[SITE_W-1:0];
      l.direction     = dir;
      l.is_last       = 1'b0;
      l.out_of_range  = 1'b0;
      return l;
   endfunction

   function automatic void predict_links(input logic [SITE_W-1:0] site);
      int unsigned      s;
      int unsigned      count;
      int unsigned      pos;
      int unsigned      row;
      int unsigned      up;
      int unsigned      down;
      int unsigned      left;
      int unsigned      right;
      lattice_link_type links[$];
      lattice_link_type bad;
      s = 32'(side_reg);
      if (s > MAX_SIDE)
         s = MAX_SIDE;
      count = s * s;
      if (s == 0 || site >= count) begin
         bad = make_link(site, 0, DIR_UP);
         bad.is_last      = 1'b1;
         bad.out_of_range = 1'b1;
         awaited_links.insert(awaited_links.size(), bad);
         return;
      end
      pos   = site % s;
      row   = site - pos;
      up    = row + (pos + s - 1) % s;
      down  = row + (pos + 1) % s;
      left  = (site + count - s) % count;
      right = (site + s) % count;
      if (topo_reg == TOPO_TORUS) begin
         links.insert(links.size(), make_link(site, up, DIR_UP));
         links.insert(links.size(), make_link(site, left, DIR_LEFT));
         links.insert(links.size(), make_link(site, down, DIR_DOWN));
         links.insert(links.size(), make_link(site, right, DIR_RIGHT));
      end else begin
         if (topo_reg == TOPO_CYLINDER) begin
            links.insert(links.size(), make_link(site, up, DIR_UP));
            links.insert(links.size(), make_link(site, down, DIR_DOWN));
         end else begin
            if (pos != 0)
               links.insert(links.size(), make_link(site, site - 1, DIR_UP));
            if (pos + 1 != s)
               links.insert(links.size(), make_link(site, site + 1, DIR_DOWN));
         end
         if (site >= s)
            links.insert(links.size(), make_link(site, site - s, DIR_LEFT));
         if (site + s < count)
            links.insert(links.size(), make_link(site, site + s, DIR_RIGHT));
      end
      if (links.size() > 0)
         links[links.size()-1].is_last = 1'b1;
      foreach (links[i])
         awaited_links.insert(awaited_links.size(), links[i]);
   endfunction

   task automatic check_field(input string name, input int unsigned want, input int unsigned got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fault_count++;
      end
   endtask

   always @(posedge clock) begin
      lattice_link_type head;
      if (reset) begin
         side_reg = SIDE_RESET;
         topo_reg = TOPO_TORUS;
         awaited_links.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            link_count++;
            if (awaited_links.size() == 0) begin
               $error("link item from site %0d with none awaited", rsp_mon.source_site);
               fault_count++;
            end else begin
               head = awaited_links.pop_front();
               check_field("source_site", 32'(head.source_site),
                           32'(rsp_mon.source_site));
               check_field("neighbor_site", 32'(head.neighbor_site),
                           32'(rsp_mon.neighbor_site));
               check_field("direction", 32'(head.direction), 32'(rsp_mon.direction));
               check_field("is_last", 32'(head.is_last), 32'(rsp_mon.is_last));
               check_field("out_of_range", 32'(head.out_of_range),
                           32'(rsp_mon.out_of_range));
            end
         end
         if (req_mon.valid && req_mon.ready)
            predict_links(req_mon.site);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[2 +: REG_IDX_W])
               REG_SIDE: side_reg = csr_pwdata[SIDE_W-1:0];
               REG_TOPO: topo_reg = csr_pwdata[TOPO_W-1:0];
               default: ;
            endcase
         end
      end
      outstanding   <= awaited_links.size();
      mismatches    <= fault_count;
      links_checked <= link_count;
   end

endmodule

// File: tb/tb_square_lattice_neighbor_generator.sv
// Testbench top for the square lattice neighbour generator.
// Drives site items, result back-pressure and register writes; the link checker
// predicts and compares. Depends on slng_pkg, slng_if and tb_slng_link_checker.
`timescale 1ns / 100ps

module tb_square_lattice_neighbor_generator import slng_pkg::*; ();

   localparam int CYCLE_LIMIT     = 300000;
   localparam int DRAIN_CYCLES    = 40;
   localparam int RSP_HOLD_CYCLES = 300;
   localparam int RANDOM_BLOCKS   = 8;
   localparam int BLOCK_ITEMS     = 42;
   localparam int HOLD_ITEMS      = 40;

   localparam logic [TOPO_W-1:0] TOPO_OPEN     = 2'd2;
   localparam logic [TOPO_W-1:0] TOPO_OPEN_ALT = 2'd3;

   logic clock = 1'b0;
   logic reset;

   slng_req_if req_chan ();
   slng_rsp_if rsp_chan ();

   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [CSR_AW-1:0] csr_paddr;
   logic [CSR_DW-1:0] csr_pwdata;
   logic [CSR_DW-1:0] csr_prdata;
   logic              csr_pready;

   int mismatches;
   int outstanding;
   int links_checked;

   int                rsp_stall_pct;
   logic              hold_go;
   int                send_idle_pct;
   int                sites_sent;
   int                settings_done;
   int                cycle_count = 0;
   logic [SIDE_W-1:0] cur_side;

   square_lattice_neighbor_generator dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   tb_slng_link_checker link_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_chan),
      .rsp_mon       (rsp_chan),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_pready    (csr_pready),
      .mismatches    (mismatches),
      .outstanding   (outstanding),
      .links_checked (links_checked)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin : rsp_pacer
      int hold_left;
      bit hold_taken;
      hold_left  = 0;
      hold_taken = 1'b0;
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (reset) begin
            rsp_chan.ready <= 1'b0;
         end else if (hold_go && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = RSP_HOLD_CYCLES;
            rsp_chan.ready <= 1'b0;
         end else if (hold_left != 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   task automatic send_site(input logic [SITE_W-1:0] site);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.site  <= site;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
      sites_sent++;
   endtask

   task automatic wait_drained();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [REG_IDX_W-1:0] idx, input logic [CSR_DW-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready)
         @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_setting(input logic [SIDE_W-1:0] side, input logic [TOPO_W-1:0] topo);
      wait_drained();
      csr_write(REG_SIDE, CSR_DW'(side));
      csr_write(REG_TOPO, CSR_DW'(topo));
      cur_side = side;
      settings_done++;
   endtask

   function automatic logic [SITE_W-1:0] pick_site();
      int unsigned s;
      int unsigned count;
      int unsigned r;
      int unsigned col;
      int unsigned site;
      s = 32'(cur_side);
      if (s > MAX_SIDE_DEF)
         s = MAX_SIDE_DEF;
      count = s * s;
      r = $urandom_range(99);
      if (count == 0 || r < 10) begin
         site = $urandom();
      end else if (r < 20) begin
         site = (count + 3 < (1 << SITE_W)) ? count + $urandom_range(3) : $urandom();
      end else if (r < 40) begin
         col = $urandom_range(s - 1);
         if ($urandom_range(1))
            site = col * s + ($urandom_range(1) ? s - 1 : 0);
         else
            site = ($urandom_range(1) ? (s - 1) * s : 0) + col;
      end else begin
         site = $urandom_range(count - 1);
      end
      return site[SITE_W-1:0];
   endfunction

   initial begin
      int r;
      logic [SIDE_W-1:0] side;
      reset          <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.site  <= '0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      rsp_stall_pct  <= 0;
      hold_go        <= 1'b0;
      send_idle_pct  = 0;
      sites_sent     = 0;
      settings_done  = 0;
      cur_side       = SIDE_RESET;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_site(20'd0);
      send_site(20'd3);
      send_site(20'd12);
      send_site(20'd15);
      send_site(20'd16);
      send_site(20'hFFFFF);
      apply_setting(11'd4, TOPO_CYLINDER);
      send_site(20'd0);
      send_site(20'd5);
      send_site(20'd15);
      apply_setting(11'd4, TOPO_OPEN);
      send_site(20'd0);
      send_site(20'd3);
      send_site(20'd12);
      send_site(20'd6);
      apply_setting(11'd4, TOPO_OPEN_ALT);
      send_site(20'd15);
      apply_setting(11'd1, TOPO_OPEN);
      send_site(20'd0);
      send_site(20'd1);
      apply_setting(11'd1, TOPO_TORUS);
      send_site(20'd0);
      apply_setting(11'd0, TOPO_TORUS);
      send_site(20'd0);
      apply_setting(11'd1024, TOPO_TORUS);
      send_site(20'd0);
      send_site(20'hFFFFF);
      apply_setting(11'd2047, TOPO_OPEN);
      send_site(20'hFFFFF);

      for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
         r = $urandom_range(99);
         if (r < 60)
            side = SIDE_W'($urandom_range(12, 1));
         else if (r < 70)
            side = 11'd1024;
         else if (r < 75)
            side = 11'd0;
         else if (r < 85)
            side = SIDE_W'($urandom_range(2047, 1025));
         else
            side = SIDE_W'($urandom_range(1023, 13));
         apply_setting(side, TOPO_W'($urandom_range(3)));
         case (blk % 4)
            0: begin send_idle_pct = 0;  rsp_stall_pct <= 0;  end
            1: begin send_idle_pct = 45; rsp_stall_pct <= 0;  end
            2: begin send_idle_pct = 0;  rsp_stall_pct <= 45; end
            default: begin send_idle_pct = 24; rsp_stall_pct <= 24; end
         endcase
         repeat (BLOCK_ITEMS) send_site(pick_site());
      end

      apply_setting(11'd8, TOPO_TORUS);
      send_idle_pct = 0;
      rsp_stall_pct <= 0;
      hold_go       <= 1'b1;
      repeat (HOLD_ITEMS) send_site(pick_site());
      wait_drained();

      $display("Summary: %0d sites accepted, %0d links compared over %0d register settings",
               sites_sent, links_checked, settings_done);
      $display("Covered torus, cylinder and open lattices, side 0 to saturation, with stalls.");
      if (mismatches == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
